// ----- hw/rtl/aaor_pkg.sv -----
`timescale 1ns / 1ps

package aaor_pkg;

  // Pipeline lengths of the iterative units.
  localparam int DIV_STEPS    = 34;  // projection quotient bits
  localparam int SQRT_STEPS   = 32;  // root bits of a 64-bit radicand
  localparam int THETA_STEPS  = 56;  // quotient bits of (|arc| << 24) / len
  localparam int MOD_STEPS    = 30;  // conditional subtracts of 2*pi << b
  localparam int CORDIC_STEPS = 24;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  localparam int LEN_W = 36;

  localparam logic signed [27:0] ANG_PI      = 28'sd52707179;
  localparam logic signed [27:0] ANG_HALF_PI = 28'sd26353589;
  localparam logic signed [27:0] ANG_TWO_PI  = 28'sd105414357;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [34:0] ONE_Q30     = 35'sd1073741824;

  typedef struct packed {
    logic [2:0][31:0] c;
    logic [2:0][31:0] p;
    logic [31:0]      arc;
    logic [2:0][15:0] n;
  } in_t;

  typedef struct packed {
    logic [2:0][31:0] c;
    logic [2:0][32:0] r;
    logic [2:0][15:0] n;
    logic [31:0]      arc;
  } geo_t;

  typedef struct packed {
    geo_t             geo;
    logic [LEN_W-1:0] len;
    logic             degen;
  } mid_t;

  typedef struct packed {
    logic [2:0][31:0] v;
    logic             degen;
  } res_t;

  function automatic logic signed [27:0] atan_q24(input int unsigned i);
    case (i)
      0:  return 28'sd13176795;
      1:  return 28'sd7778716;
      2:  return 28'sd4110060;
      3:  return 28'sd2086331;
      4:  return 28'sd1047214;
      5:  return 28'sd524117;
      6:  return 28'sd262123;
      7:  return 28'sd131069;
      8:  return 28'sd65536;
      9:  return 28'sd32768;
      10: return 28'sd16384;
      11: return 28'sd8192;
      12: return 28'sd4096;
      13: return 28'sd2048;
      14: return 28'sd1024;
      15: return 28'sd512;
      16: return 28'sd256;
      17: return 28'sd128;
      18: return 28'sd64;
      19: return 28'sd32;
      20: return 28'sd16;
      21: return 28'sd8;
      22: return 28'sd4;
      23: return 28'sd2;
      default: return 28'sd0;
    endcase
  endfunction

endpackage

// ----- hw/rtl/aaor_fifo.sv -----
`timescale 1ns / 1ps

module aaor_fifo #(
  parameter int W     = 1,
  parameter int DEPTH = aaor_pkg::MID_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/aaor_front.sv -----
`timescale 1ns / 1ps

module aaor_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_push,
  input  aaor_pkg::in_t  in_data,
  output logic           in_ready,
  output logic           mid_push,
  output aaor_pkg::mid_t mid_data,
  input  logic           mid_full
);

  localparam int NDIV = aaor_pkg::DIV_STEPS;
  localparam int NSQ  = aaor_pkg::SQRT_STEPS;
  localparam int NST  = NDIV + NSQ + 8;

  logic [NST-1:0] vld;
  logic           adv;

  // The whole pipe moves as one; it holds only when the last item cannot leave.
  assign adv      = !vld[NST-1] || !mid_full;
  assign in_ready = adv;
  assign mid_push = vld[NST-1] && !mid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_push};
    end
  end

  // Stage A: offset from the center.
  aaor_pkg::geo_t a_geo;
  aaor_pkg::geo_t a_geo_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_geo_next.c[i] = in_data.c[i];
      a_geo_next.r[i] = {in_data.p[i][31], in_data.p[i]} - {in_data.c[i][31], in_data.c[i]};
      a_geo_next.n[i] = in_data.n[i];
    end
    a_geo_next.arc = in_data.arc;
  end

  // Stage B: n.n and r.n.
  aaor_pkg::geo_t     b_geo;
  logic [31:0]        b_nn;
  logic signed [50:0] b_dot;
  logic [31:0]        b_nn_next;
  logic signed [50:0] b_dot_next;

  always_comb begin
    logic signed [33:0] nn_acc;
    logic signed [31:0] nsq;
    logic signed [48:0] rn;
    nn_acc = '0;
    b_dot_next = '0;
    for (int i = 0; i < 3; i++) begin
      nsq = $signed(a_geo.n[i]) * $signed(a_geo.n[i]);
      rn = $signed(a_geo.r[i]) * $signed(a_geo.n[i]);
      nn_acc = nn_acc + 34'(nsq);
      b_dot_next = b_dot_next + 51'(rn);
    end
    b_nn_next = nn_acc[31:0];
  end

  // Stage C loads the first divider entry; entries 1..NDIV each resolve one
  // quotient bit of |n_i|*|dot| / nn.
  logic [63:0]       c_prod [3];
  logic [32:0]       d_rem  [NDIV+1][3];
  logic [NDIV-1:0]   d_low  [NDIV+1][3];
  logic [NDIV-1:0]   d_q    [NDIV+1][3];
  logic              d_neg  [NDIV+1][3];
  logic [31:0]       d_nn   [NDIV+1];
  aaor_pkg::geo_t    d_geo  [NDIV+1];
  logic [32:0]       d_rem_next [NDIV][3];
  logic [NDIV-1:0]   d_low_next [NDIV][3];
  logic [NDIV-1:0]   d_q_next   [NDIV][3];

  always_comb begin
    logic [15:0] nm;
    logic [49:0] dm;
    logic [65:0] pw;
    dm = b_dot[50] ? 50'(-b_dot) : b_dot[49:0];
    for (int i = 0; i < 3; i++) begin
      nm = b_geo.n[i][15] ? 16'(-$signed(b_geo.n[i])) : b_geo.n[i];
      pw = 66'(nm) * 66'(dm);
      c_prod[i] = pw[63:0];
    end
  end

  always_comb begin
    logic [32:0] t;
    for (int k = 0; k < NDIV; k++) begin
      for (int i = 0; i < 3; i++) begin
        t = {d_rem[k][i][31:0], d_low[k][i][NDIV-1]};
        if (t >= {1'b0, d_nn[k]}) begin
          d_rem_next[k][i] = t - {1'b0, d_nn[k]};
          d_q_next[k][i]   = {d_q[k][i][NDIV-2:0], 1'b1};
        end else begin
          d_rem_next[k][i] = t;
          d_q_next[k][i]   = {d_q[k][i][NDIV-2:0], 1'b0};
        end
        d_low_next[k][i] = {d_low[k][i][NDIV-2:0], 1'b0};
      end
    end
  end

  // Stage E: projected offset magnitudes.
  aaor_pkg::geo_t e_geo;
  logic [34:0]    e_mag [3];
  logic           e_nz;
  logic [34:0]    e_mag_next [3];

  always_comb begin
    logic signed [35:0] pr;
    logic signed [35:0] pv;
    for (int i = 0; i < 3; i++) begin
      pr = $signed({2'b00, d_q[NDIV][i]});
      if (d_neg[NDIV][i]) begin
        pr = -pr;
      end
      pv = 36'($signed(d_geo[NDIV].r[i])) - pr;
      e_mag_next[i] = pv[35] ? 35'(-pv) : pv[34:0];
    end
  end

  // Stage F: common shift that brings every component below 2^31.
  aaor_pkg::geo_t f_geo;
  logic [30:0]    f_q [3];
  logic [2:0]     f_s;
  logic           f_nz;
  logic [30:0]    f_q_next [3];
  logic [2:0]     f_s_next;

  always_comb begin
    logic [34:0] mx;
    logic [34:0] sh;
    mx = e_mag[0];
    if (e_mag[1] > mx) begin
      mx = e_mag[1];
    end
    if (e_mag[2] > mx) begin
      mx = e_mag[2];
    end
    if (mx[34]) begin
      f_s_next = 3'd4;
    end else if (mx[33]) begin
      f_s_next = 3'd3;
    end else if (mx[32]) begin
      f_s_next = 3'd2;
    end else if (mx[31]) begin
      f_s_next = 3'd1;
    end else begin
      f_s_next = 3'd0;
    end
    for (int i = 0; i < 3; i++) begin
      sh = e_mag[i] >> f_s_next;
      f_q_next[i] = sh[30:0];
    end
  end

  // Stage W: squares.
  aaor_pkg::geo_t w_geo;
  logic [61:0]    w_sq [3];
  logic [2:0]     w_s;
  logic           w_nz;

  // Stage H loads the first root entry; entries 1..NSQ each resolve one root bit.
  logic [63:0]    s_rem  [NSQ+1];
  logic [31:0]    s_root [NSQ+1];
  logic [2:0]     s_s    [NSQ+1];
  logic           s_nz   [NSQ+1];
  aaor_pkg::geo_t s_geo  [NSQ+1];
  logic [63:0]    s_rem_next  [NSQ];
  logic [31:0]    s_root_next [NSQ];

  always_comb begin
    logic [65:0] t;
    for (int k = 0; k < NSQ; k++) begin
      t = (66'(s_root[k]) << (NSQ - k)) + (66'(1) << (2 * (NSQ - 1 - k)));
      if ({2'b00, s_rem[k]} >= t) begin
        s_rem_next[k]  = s_rem[k] - t[63:0];
        s_root_next[k] = s_root[k] | (32'(1) << (NSQ - 1 - k));
      end else begin
        s_rem_next[k]  = s_rem[k];
        s_root_next[k] = s_root[k];
      end
    end
  end

  typedef logic [aaor_pkg::LEN_W-1:0] len_t;

  aaor_pkg::mid_t i_out_next;

  always_comb begin
    i_out_next.geo   = s_geo[NSQ];
    i_out_next.len   = len_t'(s_root[NSQ]) << s_s[NSQ];
    i_out_next.degen = !s_nz[NSQ] || (s_root[NSQ] == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_geo <= a_geo_next;
      b_geo <= a_geo;
      b_nn  <= b_nn_next;
      b_dot <= b_dot_next;

      d_geo[0] <= b_geo;
      d_nn[0]  <= b_nn;
      for (int i = 0; i < 3; i++) begin
        d_rem[0][i] <= 33'(c_prod[i][63:NDIV]);
        d_low[0][i] <= c_prod[i][NDIV-1:0];
        d_q[0][i]   <= '0;
        d_neg[0][i] <= b_geo.n[i][15] ^ b_dot[50];
      end
      for (int k = 0; k < NDIV; k++) begin
        d_geo[k+1] <= d_geo[k];
        d_nn[k+1]  <= d_nn[k];
        for (int i = 0; i < 3; i++) begin
          d_rem[k+1][i] <= d_rem_next[k][i];
          d_low[k+1][i] <= d_low_next[k][i];
          d_q[k+1][i]   <= d_q_next[k][i];
          d_neg[k+1][i] <= d_neg[k][i];
        end
      end

      e_geo <= d_geo[NDIV];
      e_nz  <= (d_nn[NDIV] != '0);
      f_geo <= e_geo;
      f_s   <= f_s_next;
      f_nz  <= e_nz;
      w_geo <= f_geo;
      w_s   <= f_s;
      w_nz  <= f_nz;
      for (int i = 0; i < 3; i++) begin
        e_mag[i] <= e_mag_next[i];
        f_q[i]   <= f_q_next[i];
        w_sq[i]  <= 62'(f_q[i]) * 62'(f_q[i]);
      end

      s_geo[0]  <= w_geo;
      s_s[0]    <= w_s;
      s_nz[0]   <= w_nz;
      s_rem[0]  <= 64'(w_sq[0]) + 64'(w_sq[1]) + 64'(w_sq[2]);
      s_root[0] <= '0;
      for (int k = 0; k < NSQ; k++) begin
        s_geo[k+1]  <= s_geo[k];
        s_s[k+1]    <= s_s[k];
        s_nz[k+1]   <= s_nz[k];
        s_rem[k+1]  <= s_rem_next[k];
        s_root[k+1] <= s_root_next[k];
      end

      mid_data <= i_out_next;
    end
  end

endmodule

// ----- hw/rtl/aaor_back.sv -----
`timescale 1ns / 1ps

module aaor_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           mid_empty,
  input  aaor_pkg::mid_t mid_data,
  output logic           mid_pop,
  output logic           res_push,
  output aaor_pkg::res_t res_data,
  input  logic           res_full
);

  localparam int NTH  = aaor_pkg::THETA_STEPS;
  localparam int NMOD = aaor_pkg::MOD_STEPS;
  localparam int NCOR = aaor_pkg::CORDIC_STEPS;
  localparam int LW   = aaor_pkg::LEN_W;
  localparam int NST  = (NTH + 1) + (NMOD + 1) + (NCOR + 1) + 5;

  logic [NST-1:0] vld;
  logic           adv;

  assign adv      = !vld[NST-1] || !res_full;
  assign mid_pop  = adv && !mid_empty;
  assign res_push = vld[NST-1] && !res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], !mid_empty};
    end
  end

  // Angle divider: one quotient bit of (|arc| << 24) / len per entry.
  logic [LW-1:0]  t_rem [NTH+1];
  logic [NTH-1:0] t_low [NTH+1];
  logic [NTH-1:0] t_q   [NTH+1];
  aaor_pkg::mid_t t_m   [NTH+1];
  logic [LW-1:0]  t_rem_next [NTH];
  logic [NTH-1:0] t_q_next   [NTH];
  logic [31:0]    arc_mag;

  assign arc_mag = mid_data.geo.arc[31] ? 32'(-$signed(mid_data.geo.arc)) : mid_data.geo.arc;

  always_comb begin
    logic [LW:0] t;
    for (int k = 0; k < NTH; k++) begin
      t = {t_rem[k], t_low[k][NTH-1]};
      if (t >= {1'b0, t_m[k].len}) begin
        t_rem_next[k] = LW'(t - {1'b0, t_m[k].len});
        t_q_next[k]   = {t_q[k][NTH-2:0], 1'b1};
      end else begin
        t_rem_next[k] = t[LW-1:0];
        t_q_next[k]   = {t_q[k][NTH-2:0], 1'b0};
      end
    end
  end

  // Reduction modulo 2*pi by subtracting 2*pi << b, high b first.
  logic [NTH-1:0] m_v [NMOD+1];
  aaor_pkg::mid_t m_m [NMOD+1];
  logic [NTH-1:0] m_v_next [NMOD];

  always_comb begin
    logic [NTH:0] kb;
    for (int k = 0; k < NMOD; k++) begin
      kb = (NTH + 1)'(aaor_pkg::ANG_TWO_PI) << (NMOD - 1 - k);
      if ({1'b0, m_v[k]} >= kb) begin
        m_v_next[k] = m_v[k] - kb[NTH-1:0];
      end else begin
        m_v_next[k] = m_v[k];
      end
    end
  end

  // Fold into [-pi/2, pi/2]; a folded angle negates sin and cos.
  logic signed [27:0] fold_th;
  logic               fold_neg;

  always_comb begin
    fold_th  = $signed({1'b0, m_v[NMOD][26:0]});
    fold_neg = 1'b0;
    if (fold_th > aaor_pkg::ANG_PI) begin
      fold_th = fold_th - aaor_pkg::ANG_TWO_PI;
    end
    if (m_m[NMOD].geo.arc[31]) begin
      fold_th = -fold_th;
    end
    if (fold_th > aaor_pkg::ANG_HALF_PI) begin
      fold_th  = fold_th - aaor_pkg::ANG_PI;
      fold_neg = 1'b1;
    end else if (fold_th < -aaor_pkg::ANG_HALF_PI) begin
      fold_th  = fold_th + aaor_pkg::ANG_PI;
      fold_neg = 1'b1;
    end
  end

  // CORDIC rotation, one micro-rotation per entry.
  logic signed [33:0] c_x [NCOR+1];
  logic signed [33:0] c_y [NCOR+1];
  logic signed [27:0] c_z [NCOR+1];
  logic               c_neg [NCOR+1];
  aaor_pkg::mid_t     c_m [NCOR+1];
  logic signed [33:0] c_x_next [NCOR];
  logic signed [33:0] c_y_next [NCOR];
  logic signed [27:0] c_z_next [NCOR];

  always_comb begin
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    for (int k = 0; k < NCOR; k++) begin
      dx = c_y[k] >>> k;
      dy = c_x[k] >>> k;
      if (c_z[k] >= 0) begin
        c_x_next[k] = c_x[k] - dx;
        c_y_next[k] = c_y[k] + dy;
        c_z_next[k] = c_z[k] - aaor_pkg::atan_q24(k);
      end else begin
        c_x_next[k] = c_x[k] + dx;
        c_y_next[k] = c_y[k] - dy;
        c_z_next[k] = c_z[k] + aaor_pkg::atan_q24(k);
      end
    end
  end

  // Matrix stages.
  aaor_pkg::mid_t     m1_m;
  logic signed [33:0] m1_cs;
  logic signed [33:0] m1_sn;
  logic signed [34:0] m1_omc;
  logic signed [31:0] m1_nij [3][3];

  aaor_pkg::mid_t     m2_m;
  logic signed [33:0] m2_cs;
  logic signed [66:0] m2_pij [3][3];
  logic signed [49:0] m2_ns  [3];

  aaor_pkg::mid_t     m3_m;
  logic signed [30:0] m3_e [3][3];
  logic signed [30:0] m3_e_next [3][3];

  aaor_pkg::mid_t     m4_m;
  logic signed [63:0] m4_pr [3][3];

  aaor_pkg::res_t     m5_next;

  logic signed [33:0] cs_sel;
  logic signed [33:0] sn_sel;

  assign cs_sel = c_neg[NCOR] ? -c_x[NCOR] : c_x[NCOR];
  assign sn_sel = c_neg[NCOR] ? -c_y[NCOR] : c_y[NCOR];

  always_comb begin
    logic signed [39:0] mv [3][3];
    logic signed [39:0] nsv [3];
    logic signed [39:0] diag;
    diag = 40'(m2_cs >>> 2);
    for (int i = 0; i < 3; i++) begin
      nsv[i] = 40'(m2_ns[i] >>> 16);
      for (int j = 0; j < 3; j++) begin
        mv[i][j] = 40'(m2_pij[i][j] >>> 30);
        if (i == j) begin
          mv[i][j] = mv[i][j] + diag;
        end
      end
    end
    mv[0][1] = mv[0][1] - nsv[2];
    mv[0][2] = mv[0][2] + nsv[1];
    mv[1][0] = mv[1][0] + nsv[2];
    mv[1][2] = mv[1][2] - nsv[0];
    mv[2][0] = mv[2][0] - nsv[1];
    mv[2][1] = mv[2][1] + nsv[0];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (mv[i][j] > 40'sd536870912) begin
          m3_e_next[i][j] = 31'sd536870912;
        end else if (mv[i][j] < -40'sd536870912) begin
          m3_e_next[i][j] = -31'sd536870912;
        end else begin
          m3_e_next[i][j] = mv[i][j][30:0];
        end
      end
    end
  end

  always_comb begin
    logic signed [65:0] acc;
    logic signed [65:0] sh;
    for (int i = 0; i < 3; i++) begin
      acc = (66'($signed(m4_m.geo.c[i])) <<< 28) + 66'sd134217728;
      for (int j = 0; j < 3; j++) begin
        acc = acc + 66'(m4_pr[i][j]);
      end
      sh = acc >>> 28;
      if (m4_m.degen) begin
        // Degenerate item: hand back the original point.
        m5_next.v[i] = m4_m.geo.c[i] + m4_m.geo.r[i][31:0];
      end else if (sh > 66'sd2147483647) begin
        m5_next.v[i] = 32'h7FFF_FFFF;
      end else if (sh < -66'sd2147483648) begin
        m5_next.v[i] = 32'h8000_0000;
      end else begin
        m5_next.v[i] = sh[31:0];
      end
    end
    m5_next.degen = m4_m.degen;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_m[0]   <= mid_data;
      t_rem[0] <= '0;
      t_low[0] <= {arc_mag, 24'd0};
      t_q[0]   <= '0;
      for (int k = 0; k < NTH; k++) begin
        t_m[k+1]   <= t_m[k];
        t_rem[k+1] <= t_rem_next[k];
        t_low[k+1] <= {t_low[k][NTH-2:0], 1'b0};
        t_q[k+1]   <= t_q_next[k];
      end

      m_m[0] <= t_m[NTH];
      m_v[0] <= t_q[NTH];
      for (int k = 0; k < NMOD; k++) begin
        m_m[k+1] <= m_m[k];
        m_v[k+1] <= m_v_next[k];
      end

      c_m[0]   <= m_m[NMOD];
      c_x[0]   <= aaor_pkg::CORDIC_GAIN;
      c_y[0]   <= '0;
      c_z[0]   <= fold_th;
      c_neg[0] <= fold_neg;
      for (int k = 0; k < NCOR; k++) begin
        c_m[k+1]   <= c_m[k];
        c_x[k+1]   <= c_x_next[k];
        c_y[k+1]   <= c_y_next[k];
        c_z[k+1]   <= c_z_next[k];
        c_neg[k+1] <= c_neg[k];
      end

      m1_m   <= c_m[NCOR];
      m1_cs  <= cs_sel;
      m1_sn  <= sn_sel;
      m1_omc <= aaor_pkg::ONE_Q30 - 35'(cs_sel);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m1_nij[i][j] <= $signed(c_m[NCOR].geo.n[i]) * $signed(c_m[NCOR].geo.n[j]);
        end
      end

      m2_m  <= m1_m;
      m2_cs <= m1_cs;
      for (int i = 0; i < 3; i++) begin
        m2_ns[i] <= $signed(m1_m.geo.n[i]) * m1_sn;
        for (int j = 0; j < 3; j++) begin
          m2_pij[i][j] <= m1_omc * m1_nij[i][j];
        end
      end

      m3_m <= m2_m;
      m3_e <= m3_e_next;

      m4_m <= m3_m;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m4_pr[i][j] <= m3_e[i][j] * $signed(m3_m.geo.r[j]);
        end
      end

      res_data <= m5_next;
    end
  end

endmodule

// ----- hw/rtl/axis_angle_orbit_rotate.sv -----
`timescale 1ns / 1ps

// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// input    | push / full          | center_*, point_*, arc_distance, axis_*
// result   | empty / pop          | out_x, out_y, out_z, degenerate
//
// One item is taken per cycle while full is low; every pipeline stage holds one item.
// A result passes the bit-per-stage projection divider, square root, angle divider, 2*pi
// reduction, the 24-stage CORDIC and the queue after each half.
// rst is synchronous; it empties both pipelines and both queues.
// Each half stalls as a whole when its last item cannot enter the full queue after it.
module axis_angle_orbit_rotate #(
  parameter int MID_DEPTH = aaor_pkg::MID_DEPTH,
  parameter int OUT_DEPTH = aaor_pkg::OUT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] center_x,
  input  logic [31:0] center_y,
  input  logic [31:0] center_z,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  input  logic [31:0] point_z,
  input  logic [31:0] arc_distance,
  input  logic [15:0] axis_x,
  input  logic [15:0] axis_y,
  input  logic [15:0] axis_z,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic        degenerate
);

  aaor_pkg::in_t  in_data;
  aaor_pkg::mid_t front_data;
  aaor_pkg::mid_t mid_head;
  aaor_pkg::res_t back_data;
  aaor_pkg::res_t res_head;
  logic           front_ready;
  logic           front_push;
  logic           mid_full;
  logic           mid_empty;
  logic           mid_pop;
  logic           back_push;
  logic           res_full;

  assign in_data.c   = {center_z, center_y, center_x};
  assign in_data.p   = {point_z, point_y, point_x};
  assign in_data.arc = arc_distance;
  assign in_data.n   = {axis_z, axis_y, axis_x};

  assign full = !front_ready;

  aaor_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_push  (push),
    .in_data  (in_data),
    .in_ready (front_ready),
    .mid_push (front_push),
    .mid_data (front_data),
    .mid_full (mid_full)
  );

  aaor_fifo #(
    .W     ($bits(aaor_pkg::mid_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .din   (front_data),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_head),
    .empty (mid_empty)
  );

  aaor_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_data  (mid_head),
    .mid_pop   (mid_pop),
    .res_push  (back_push),
    .res_data  (back_data),
    .res_full  (res_full)
  );

  aaor_fifo #(
    .W     ($bits(aaor_pkg::res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (back_push),
    .din   (back_data),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_head),
    .empty (empty)
  );

  assign out_x      = res_head.v[0];
  assign out_y      = res_head.v[1];
  assign out_z      = res_head.v[2];
  assign degenerate = res_head.degen;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam longint LIMIT_CYCLES = 2000000;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam longint M_LIM = 64'sd536870912;
  localparam longint PI_Q24 = 64'sd52707179;
  localparam longint HALF_PI_Q24 = 64'sd26353589;
  localparam longint TWO_PI_Q24 = 64'sd105414357;
  localparam longint START_GAIN = 64'sd652032874;
  localparam longint ONE30 = 64'sd1073741824;
  localparam longint ARCTAN[24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  logic clk, rst, push, full, empty, pop, degenerate;
  logic [31:0] center_x, center_y, center_z, point_x, point_y, point_z, arc_distance;
  logic [15:0] axis_x, axis_y, axis_z;
  logic [31:0] out_x, out_y, out_z;

  axis_angle_orbit_rotate u_top (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .arc_distance(arc_distance), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
    .empty(empty), .pop(pop), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .degenerate(degenerate)
  );

  aaor_pkg::res_t rotated_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_degen = 0;
  longint cycles = 0;
  bit tx_calm = 0;
  bit rx_calm = 0;
  int stall_left = 0;
  int pick;
  aaor_pkg::res_t got, want;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  // Rotates the point about the axis through the center by arc / projected radius.
  function automatic aaor_pkg::res_t rotate_about_axis(aaor_pkg::in_t it);
    longint c[3], r[3], n[3], ns[3], m[3][3];
    longint nn, dot, pr, pj, th, x, y, z, dx, dy, cs, sn, omc, acc, arc, mm;
    logic [127:0] prod;
    longint unsigned mx, sum, len, q, v, res, bitv;
    int s;
    bit neg;
    aaor_pkg::res_t o;
    for (int i = 0; i < 3; i++) begin
      c[i] = longint'($signed(it.c[i]));
      r[i] = longint'($signed(it.p[i])) - c[i];
      n[i] = longint'($signed(it.n[i]));
    end
    nn = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    dot = r[0] * n[0] + r[1] * n[1] + r[2] * n[2];
    len = 0;
    mx = 0;
    sum = 0;
    s = 0;
    neg = 0;
    if (nn != 0) begin
      for (int i = 0; i < 3; i++) begin
        prod = {64'd0, magnitude(n[i])} * {64'd0, magnitude(dot)};
        pr = longint'(prod / {64'd0, nn});
        if ((n[i] < 0) != (dot < 0)) pr = -pr;
        pj = r[i] - pr;
        if (magnitude(pj) > mx) mx = magnitude(pj);
        r[i] = r[i];
        ns[i] = pj;
      end
      while ((mx >> s) >= 64'd2147483648) s++;
      for (int i = 0; i < 3; i++) begin
        q = magnitude(ns[i]) >> s;
        sum += q * q;
      end
      // Bitwise integer square root.
      v = sum;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      len = res << s;
    end
    if (len == 0) begin
      for (int i = 0; i < 3; i++) o.v[i] = it.p[i];
      o.degen = 1;
      return o;
    end
    arc = longint'($signed(it.arc));
    th = longint'(((magnitude(arc) << 24) / len) % longint'(TWO_PI_Q24));
    if (th > PI_Q24) th -= TWO_PI_Q24;
    if (arc < 0) th = -th;
    if (th > HALF_PI_Q24) begin
      th -= PI_Q24;
      neg = 1;
    end else if (th < -HALF_PI_Q24) begin
      th += PI_Q24;
      neg = 1;
    end
    x = START_GAIN;
    y = 0;
    z = th;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    cs = neg ? -x : x;
    sn = neg ? -y : y;
    omc = ONE30 - cs;
    for (int i = 0; i < 3; i++) ns[i] = (n[i] * sn) >>> 16;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = ((omc * (n[i] * n[j])) >>> 30) + (i == j ? (cs >>> 2) : 64'sd0);
    m[0][1] -= ns[2]; m[0][2] += ns[1];
    m[1][0] += ns[2]; m[1][2] -= ns[0];
    m[2][0] -= ns[1]; m[2][1] += ns[0];
    for (int i = 0; i < 3; i++) begin
      acc = c[i] * 64'sd268435456 + 64'sd134217728;
      for (int j = 0; j < 3; j++) begin
        mm = m[i][j] < -M_LIM ? -M_LIM : (m[i][j] > M_LIM ? M_LIM : m[i][j]);
        acc += mm * r[j];
      end
      acc = acc >>> 28;
      acc = acc > SAT_HI ? SAT_HI : (acc < SAT_LO ? SAT_LO : acc);
      o.v[i] = acc[31:0];
    end
    o.degen = 0;
    return o;
  endfunction

  task automatic send_item(aaor_pkg::in_t it);
    int gap;
    center_x <= it.c[0]; center_y <= it.c[1]; center_z <= it.c[2];
    point_x <= it.p[0]; point_y <= it.p[1]; point_z <= it.p[2];
    arc_distance <= it.arc;
    axis_x <= it.n[0]; axis_y <= it.n[1]; axis_z <= it.n[2];
    push <= 1;
    do @(posedge clk); while (full);
    rotated_q.push_back(rotate_about_axis(it));
    n_sent++;
    if (tx_calm) gap = 0;
    else if ($urandom_range(0, 29) == 0) gap = $urandom_range(20, 70);
    else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
    else gap = 0;
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    push <= 0;
    while (rotated_q.size() != 0) @(posedge clk);
  endtask

  function automatic aaor_pkg::in_t make_item(longint cx, longint cy, longint cz,
                                              longint px, longint py, longint pz,
                                              longint arc, int nx, int ny, int nz);
    aaor_pkg::in_t it;
    it.c[0] = cx[31:0]; it.c[1] = cy[31:0]; it.c[2] = cz[31:0];
    it.p[0] = px[31:0]; it.p[1] = py[31:0]; it.p[2] = pz[31:0];
    it.arc = arc[31:0];
    it.n[0] = nx[15:0]; it.n[1] = ny[15:0]; it.n[2] = nz[15:0];
    return it;
  endfunction

  task automatic test_directed();
    // Quarter turn about z of a unit-radius offset, both directions; then about half a turn about x.
    send_item(make_item(0, 0, 0, 65536, 0, 0, 102944, 0, 0, 16384));
    send_item(make_item(0, 0, 0, 65536, 0, 0, -102944, 0, 0, 16384));
    send_item(make_item(65536, -65536, 0, 196608, 0, 4096, 205887, 16384, 0, 0));
    // Zero axis and a point on the axis line are degenerate.
    send_item(make_item(100, 200, 300, 400, 500, 600, 65536, 0, 0, 0));
    send_item(make_item(0, 0, 0, 0, 0, 5000, 65536, 0, 0, 16384));
    send_item(make_item(7, 7, 7, 7, 7, 7, -65536, 0, 16384, 0));
    // Extremes of coordinates, arcs and axis words.
    send_item(make_item(SAT_HI, SAT_HI, SAT_HI, SAT_LO, SAT_LO, SAT_LO, SAT_HI,
                        16384, 16384, 16384));
    send_item(make_item(SAT_LO, SAT_LO, SAT_LO, SAT_HI, SAT_HI, SAT_HI, SAT_LO,
                        -16384, -16384, -16384));
    send_item(make_item(SAT_LO, 0, SAT_HI, SAT_HI, 0, SAT_LO, SAT_LO, 32767, -32768, 1));
    send_item(make_item(0, 0, 0, 1, 0, 0, SAT_HI, 0, 0, 16384));
    send_item(make_item(0, 0, 0, 1, 0, 0, SAT_LO, 0, 0, -32768));
    send_item(make_item(0, 0, 0, -1, -1, -1, 0, -32768, 32767, -32768));
    // A non-unit axis, diagonal axes, large angles and a tiny arc.
    send_item(make_item(1000, 2000, 3000, 900000, -700000, 50000, 40000000, 100, 0, 3));
    send_item(make_item(0, 0, 0, 65536, 65536, 0, 2000000000, 11585, 11585, 0));
    send_item(make_item(-5, 9, 0, 32768, -32768, 12345, 205887, 9459, 9459, 9459));
    send_item(make_item(0, 0, 0, 65536, 0, 0, 205887, 0, 0, 16384));
    send_item(make_item(0, 0, 0, 65536, 0, 0, 308831, 0, 0, -16384));
    send_item(make_item(SAT_HI, SAT_LO, 0, SAT_LO, SAT_HI, 0, 1, 0, 0, 16384));
    wait_drained();
  endtask

  function automatic aaor_pkg::in_t random_orbit();
    aaor_pkg::in_t it;
    longint cen, off, arc;
    int k;
    k = $urandom_range(0, 5);
    for (int i = 0; i < 3; i++) begin
      cen = longint'($signed($urandom_range(0, 32'h1fffffff))) - 64'sd268435456;
      off = longint'($urandom_range(0, 32'h01ffffff)) - 64'sd16777216;
      it.c[i] = cen[31:0];
      it.p[i] = cen[31:0] + off[31:0];
    end
    arc = longint'($urandom_range(0, 32'h07ffffff)) - 64'sd67108864;
    it.arc = arc[31:0];
    it.n[0] = '0; it.n[1] = '0; it.n[2] = '0;
    case (k)
      0, 1: it.n[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      2: begin
        it.n[0] = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
        it.n[1] = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
      end
      3: for (int i = 0; i < 3; i++)
           it.n[i] = $urandom_range(0, 1) ? 16'sd9459 : -16'sd9459;
      default: for (int i = 0; i < 3; i++)
                 it.n[i] = 16'($urandom_range(0, 32768)) - 16'd16384;
    endcase
    return it;
  endfunction

  function automatic aaor_pkg::in_t random_noise();
    aaor_pkg::in_t it;
    for (int i = 0; i < 3; i++) begin
      it.c[i] = $urandom;
      it.p[i] = $urandom;
      it.n[i] = 16'($urandom);
    end
    it.arc = $urandom;
    return it;
  endfunction

  task automatic test_random_orbits(int count);
    for (int k = 0; k < count; k++) send_item(random_orbit());
    wait_drained();
  endtask

  task automatic test_random_noise(int count);
    for (int k = 0; k < count; k++) send_item(random_noise());
    wait_drained();
  endtask

  // Back-to-back items against a receiver that never stalls, then the opposite.
  task automatic test_steady_stream(int count);
    tx_calm = 1;
    rx_calm = 1;
    for (int k = 0; k < count; k++) send_item(random_orbit());
    rx_calm = 0;
    for (int k = 0; k < count; k++) send_item(random_orbit());
    tx_calm = 0;
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      got.v[0] = out_x; got.v[1] = out_y; got.v[2] = out_z;
      got.degen = degenerate;
      if (rotated_q.size() == 0) begin
        $error("result with nothing expected: x=%h y=%h z=%h", out_x, out_y, out_z);
        errors++;
      end else begin
        want = rotated_q.pop_front();
        n_checked++;
        if (want.degen) n_degen++;
        if (got.v[0] !== want.v[0]) begin
          $error("out_x expected %h got %h", want.v[0], got.v[0]); errors++;
        end
        if (got.v[1] !== want.v[1]) begin
          $error("out_y expected %h got %h", want.v[1], got.v[1]); errors++;
        end
        if (got.v[2] !== want.v[2]) begin
          $error("out_z expected %h got %h", want.v[2], got.v[2]); errors++;
        end
        if (got.degen !== want.degen) begin
          $error("degenerate expected %b got %b", want.degen, got.degen); errors++;
        end
      end
    end
    if (rst) begin
      pop <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pop <= 0;
    end else if (rx_calm) begin
      pop <= 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        pop <= 1;
      end else begin
        pop <= 0;
        stall_left <= pick < 97 ? $urandom_range(0, 3) : $urandom_range(20, 80);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               rotated_q.size());
      $display("axis_angle_orbit_rotate: mismatch");
      $finish;
    end
  end

  initial begin
    rst <= 1;
    push <= 0;
    center_x <= 0; center_y <= 0; center_z <= 0;
    point_x <= 0; point_y <= 0; point_z <= 0;
    arc_distance <= 0;
    axis_x <= 0; axis_y <= 0; axis_z <= 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random_orbits(450);
    test_steady_stream(100);
    test_random_noise(150);
    test_random_orbits(150);
    wait_drained();
    repeat (300) @(posedge clk);
    $display("sent %0d items, checked %0d results (%0d degenerate)", n_sent, n_checked,
             n_degen);
    $display("covered axis-aligned, diagonal and skewed axes, full-range noise and stalls");
    if (errors == 0 && rotated_q.size() == 0) begin
      $display("axis_angle_orbit_rotate: match");
    end else begin
      $display("axis_angle_orbit_rotate: mismatch");
    end
    $finish;
  end

endmodule
